### rtl/mf3_pkg.sv
// Shared types, constants and compare functions of the 3x3 median filter.
`default_nettype none

package mf3_pkg;

  // Fixed field widths
  localparam int PIX_W    = 32;
  localparam int ROW_W    = 12;
  localparam int COL_W    = 11;
  localparam int CFG_WW   = 12;
  localparam int CFG_HW   = 13;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Register reset values and limits
  localparam logic [CFG_WW-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_HW-1:0] HEIGHT_RST = 13'd480;
  localparam logic [CFG_HW-1:0] MIN_SIZE   = 13'd3;
  localparam logic [CFG_HW-1:0] MAX_HEIGHT = 13'd4096;

  // Register index, taken from the word address
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             start_of_frame;
  } in_data_t;

  typedef struct packed {
    logic [PIX_W-1:0] median;
    logic [ROW_W-1:0] center_row;
    logic [COL_W-1:0] center_col;
    logic             last;
  } out_data_t;

  // One window column, sorted from low to high
  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] md;
    logic [PIX_W-1:0] hi;
  } col_t;

  // Three sorted columns, newest first (c2 is the newest, c0 the oldest)
  typedef struct packed {
    col_t c2;
    col_t c1;
    col_t c0;
  } win_t;

  // Control of the window stage, passed to the median stage
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } s2_ctl_t;

  function automatic logic [PIX_W-1:0] min2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIX_W-1:0] max2(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a < b) ? b : a;
  endfunction

  function automatic logic [PIX_W-1:0] med3(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b,
                                            input logic [PIX_W-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Three-input sort: two levels of compare-exchange plus one more.
  function automatic col_t sort3(input logic [PIX_W-1:0] a,
                                 input logic [PIX_W-1:0] b,
                                 input logic [PIX_W-1:0] c);
    col_t             res;
    logic [PIX_W-1:0] l1;
    logic [PIX_W-1:0] h1;
    logic [PIX_W-1:0] t;
    l1     = min2(a, b);
    h1     = max2(a, b);
    res.hi = max2(h1, c);
    t      = min2(h1, c);
    res.lo = min2(l1, t);
    res.md = max2(l1, t);
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/mf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mf3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address written in the same cycle returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/mf3_median.sv
// Median-of-nine network over sorted window columns, with the output register.
`default_nettype none

module mf3_median (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire mf3_pkg::win_t      win,
  input  wire mf3_pkg::s2_ctl_t   ctl,
  input  wire logic               out_stall,
  output logic                    out_valid,
  output mf3_pkg::out_data_t      out_data,
  output logic                    out_ready
);

  logic [mf3_pkg::PIX_W-1:0] lo_max;
  logic [mf3_pkg::PIX_W-1:0] md_med;
  logic [mf3_pkg::PIX_W-1:0] hi_min;
  logic [mf3_pkg::PIX_W-1:0] median;
  logic                      out_valid_r;
  mf3_pkg::out_data_t        out_data_r;

  // Largest of the column minima, median of the middles, smallest of the maxima.
  always_comb begin
    lo_max = mf3_pkg::max2(mf3_pkg::max2(win.c0.lo, win.c1.lo), win.c2.lo);
    md_med = mf3_pkg::med3(win.c0.md, win.c1.md, win.c2.md);
    hi_min = mf3_pkg::min2(mf3_pkg::min2(win.c0.hi, win.c1.hi), win.c2.hi);
    median = mf3_pkg::med3(lo_max, md_med, hi_min);
  end

  // The output register is free when empty or when its transfer completes.
  assign out_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && ctl.valid) begin
      out_data_r.median     <= median;
      out_data_r.center_row <= ctl.row;
      out_data_r.center_col <= ctl.col;
      out_data_r.last       <= ctl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/median_filter_3x3.sv
// Top level of the 3x3 median filter over a raster stream of 32-bit pixel words.
//
// Pixels enter on the in_ channel in raster order; start_of_frame marks the
// first pixel of a frame and restarts the row and column counters. Once the
// pixel at row r, column c (both at least 2) is taken, one result leaves on
// the out_ channel: the fifth smallest unsigned word of the 3x3 window centered
// at row r-1, column c-1, with that position and a flag on the last result of
// the frame. Border pixels give no result.
// A result passes the stage 1 registers, the stage 2 window register and the
// output register before it leaves. The block takes one pixel per cycle while
// the out_ channel is not stalled; the line stores are two RAMs read at the
// column of the arriving pixel and written back when that pixel moves on, with
// a bypass when both touch the same column in one cycle.
// A stall on the out_ channel holds the result register and backs the pipeline
// up until in_stall rises; no result is lost or repeated.
// Reset clears the counters, the window and all valid flags and loads
// image_width = 640 and image_height = 480. Line stores need no clearing: an
// entry not yet written only reaches windows that give no result. The user must
// write the frame size over the APB port only while the block is idle; not enforced.
`default_nettype none

module median_filter_3x3 #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Pixel input
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire mf3_pkg::in_data_t             in_data,
  // Result output
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mf3_pkg::out_data_t                 out_data,
  // Configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mf3_pkg::APB_AW-1:0]    paddr,
  input  wire logic [mf3_pkg::APB_DW-1:0]    pwdata,
  output logic      [mf3_pkg::APB_DW-1:0]    prdata,
  output logic                               pready
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW1 = $clog2(MAX_WIDTH + 1);

  // Configuration registers
  logic [mf3_pkg::CFG_WW-1:0] width_r;
  logic [mf3_pkg::CFG_HW-1:0] height_r;
  mf3_pkg::cfg_reg_t          reg_sel;
  logic                       cfg_we;

  // Effective frame size
  logic [CW1-1:0]             w_eff;
  logic [mf3_pkg::CFG_HW-1:0] h_eff;

  // Position counters
  logic [AW-1:0]              col_r;
  logic [mf3_pkg::ROW_W-1:0]  row_r;
  logic [AW-1:0]              c_cur;
  logic [mf3_pkg::ROW_W-1:0]  r_cur;
  logic [CW1-1:0]             c_inc;
  logic [mf3_pkg::CFG_HW-1:0] r_inc;
  logic                       col_end;
  logic                       row_end;
  logic [AW-1:0]              col_nxt;
  logic [mf3_pkg::ROW_W-1:0]  row_nxt;

  // Handshake
  logic                       in_accept;
  logic                       ready_1;
  logic                       ready_2;
  logic                       s1_fire;
  logic                       out_ready;

  // Stage 1: line store read data is valid here
  logic                       v1_r;
  logic [mf3_pkg::PIX_W-1:0]  px1_r;
  logic [AW-1:0]              idx1_r;
  logic                       hz1_r;
  logic [mf3_pkg::PIX_W-1:0]  fwd_up_r;
  logic [mf3_pkg::PIX_W-1:0]  fwd_mid_r;
  logic                       emit1_r;
  logic [mf3_pkg::ROW_W-1:0]  row1_r;
  logic [mf3_pkg::COL_W-1:0]  col1_r;
  logic                       last1_r;
  logic [mf3_pkg::PIX_W-1:0]  up_rdata;
  logic [mf3_pkg::PIX_W-1:0]  mid_rdata;
  logic [mf3_pkg::PIX_W-1:0]  up_eff;
  logic [mf3_pkg::PIX_W-1:0]  mid_eff;
  mf3_pkg::col_t              col_new;

  // Stage 2: window
  mf3_pkg::win_t              win_r;
  logic                       v2_r;
  logic [mf3_pkg::ROW_W-1:0]  row2_r;
  logic [mf3_pkg::COL_W-1:0]  col2_r;
  logic                       last2_r;
  mf3_pkg::s2_ctl_t           s2_ctl;

  // APB register access
  assign reg_sel = mf3_pkg::cfg_reg_t'(paddr[2]);
  assign cfg_we  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_sel)
      mf3_pkg::REG_IMAGE_WIDTH:  prdata = mf3_pkg::APB_DW'(width_r);
      mf3_pkg::REG_IMAGE_HEIGHT: prdata = mf3_pkg::APB_DW'(height_r);
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mf3_pkg::WIDTH_RST;
      height_r <= mf3_pkg::HEIGHT_RST;
    end else if (cfg_we) begin
      case (reg_sel)
        mf3_pkg::REG_IMAGE_WIDTH:  width_r  <= pwdata[mf3_pkg::CFG_WW-1:0];
        mf3_pkg::REG_IMAGE_HEIGHT: height_r <= pwdata[mf3_pkg::CFG_HW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size to what the line stores and counters can hold.
  always_comb begin
    if (mf3_pkg::CFG_HW'(width_r) < mf3_pkg::MIN_SIZE) begin
      w_eff = CW1'(3);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = CW1'(MAX_WIDTH);
    end else begin
      w_eff = CW1'(width_r);
    end
    if (height_r < mf3_pkg::MIN_SIZE) begin
      h_eff = mf3_pkg::MIN_SIZE;
    end else if (height_r > mf3_pkg::MAX_HEIGHT) begin
      h_eff = mf3_pkg::MAX_HEIGHT;
    end else begin
      h_eff = height_r;
    end
  end

  // Pipeline flow control
  assign ready_2   = !v2_r || out_ready;
  assign ready_1   = !v1_r || ready_2;
  assign in_stall  = !ready_1;
  assign in_accept = in_valid && ready_1;
  assign s1_fire   = v1_r && ready_2;

  // Position of the arriving pixel and the next counter values
  always_comb begin
    c_cur   = in_data.start_of_frame ? '0 : col_r;
    r_cur   = in_data.start_of_frame ? '0 : row_r;
    c_inc   = CW1'(c_cur) + CW1'(1);
    r_inc   = mf3_pkg::CFG_HW'(r_cur) + mf3_pkg::CFG_HW'(1);
    col_end = (c_inc >= w_eff);
    row_end = (r_inc >= h_eff);
    if (col_end) begin
      col_nxt = '0;
      row_nxt = row_end ? '0 : r_inc[mf3_pkg::ROW_W-1:0];
    end else begin
      col_nxt = c_inc[AW-1:0];
      row_nxt = r_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Line stores: read at acceptance, written back when stage 1 moves on.
  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (idx1_r),
    .wdata (mid_eff),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (up_rdata)
  );

  mf3_ram #(
    .WIDTH (mf3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk   (clk),
    .we    (s1_fire),
    .waddr (idx1_r),
    .wdata (px1_r),
    .re    (in_accept),
    .raddr (c_cur),
    .rdata (mid_rdata)
  );

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ready_1) begin
      v1_r <= in_accept;
    end
  end

  // When the pixel ahead writes the same column at this transfer, the RAM
  // returns the old words, so its write data is kept for a bypass.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      px1_r     <= in_data.pixel;
      idx1_r    <= c_cur;
      hz1_r     <= v1_r && (idx1_r == c_cur);
      fwd_up_r  <= mid_eff;
      fwd_mid_r <= px1_r;
      emit1_r   <= (r_cur >= mf3_pkg::ROW_W'(2)) && (c_cur >= AW'(2));
      row1_r    <= r_cur - mf3_pkg::ROW_W'(1);
      col1_r    <= mf3_pkg::COL_W'(c_cur - AW'(1));
      last1_r   <= (r_inc == h_eff) && (c_inc == w_eff);
    end
  end

  // Column entering the window, sorted once on its way in
  always_comb begin
    up_eff  = hz1_r ? fwd_up_r  : up_rdata;
    mid_eff = hz1_r ? fwd_mid_r : mid_rdata;
    col_new = mf3_pkg::sort3(up_eff, mid_eff, px1_r);
  end

  // Stage 2: window shift and result control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      v2_r  <= 1'b0;
    end else if (s1_fire) begin
      win_r.c0 <= win_r.c1;
      win_r.c1 <= win_r.c2;
      win_r.c2 <= col_new;
      v2_r     <= emit1_r;
    end else if (out_ready) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      last2_r <= last1_r;
    end
  end

  assign s2_ctl.valid = v2_r;
  assign s2_ctl.row   = row2_r;
  assign s2_ctl.col   = col2_r;
  assign s2_ctl.last  = last2_r;

  mf3_median u_median (
    .clk       (clk),
    .rst_n     (rst_n),
    .win       (win_r),
    .ctl       (s2_ctl),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_ready (out_ready)
  );

endmodule

`default_nettype wire

### rtl/mf3_checker.sv
// Port-level assertions for the 3x3 median filter and their binding.
`default_nettype none

module mf3_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire mf3_pkg::out_data_t out_data
);

  // A stalled result stays and keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Reset empties the pipeline: no result and no backpressure after it.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Reported window centers are never in row 0 or column 0.
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.center_row != '0 && out_data.center_col != '0)
    else $error("result reported for a border position");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
